// ----- hdl/i2crf_pkg.sv -----
package i2crf_pkg;

	// Request kinds handed from the classifier to the sequencer
	typedef enum logic [1:0] {
		REQ_NOP   = 2'd0,
		REQ_START = 2'd1,
		REQ_EVENT = 2'd2
	} req_kind_t;

	// Transfer modes
	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_RD1  = 2'd1,
		MODE_RDN  = 2'd2,
		MODE_WR   = 2'd3
	} mode_t;

	// Status event after priority reduction (start, addr, btf, rxne, txe, error)
	typedef enum logic [2:0] {
		SIG_SB   = 3'd0,
		SIG_ADDR = 3'd1,
		SIG_BTF  = 3'd2,
		SIG_RXNE = 3'd3,
		SIG_TXE  = 3'd4,
		SIG_ERR  = 3'd5
	} sig_t;

	// Sequencer phases, one-hot
	typedef enum logic [5:0] {
		P_IDLE  = 6'b000001,
		P_START = 6'b000010,
		P_ADDR  = 6'b000100,
		P_REG   = 6'b001000,
		P_XFER  = 6'b010000,
		P_TAIL  = 6'b100000
	} phase_t;

	typedef enum logic [3:0] {
		A_NOP    = 4'd0,
		A_SEQ    = 4'd1,
		A_BUS    = 4'd2,
		A_ADDR_W = 4'd3,
		A_REG    = 4'd4,
		A_REG_RS = 4'd5,
		A_ADDR_R = 4'd6,
		A_RDBTF  = 4'd7,
		A_FIN    = 4'd8,
		A_LEN1   = 4'd9,
		A_DATA   = 4'd10
	} act_t;

	// Command opcodes
	localparam logic [1:0] OP_EVENT = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Result codes
	localparam logic [1:0] ACK_KEEP    = 2'd0;
	localparam logic [1:0] ACK_ENABLE  = 2'd1;
	localparam logic [1:0] ACK_DISABLE = 2'd2;

	localparam logic [1:0] RST_NONE   = 2'd0;
	localparam logic [1:0] RST_SWRST  = 2'd1;
	localparam logic [1:0] RST_CYCLE  = 2'd2;

	localparam logic [1:0] ST_BUSY    = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_BUS_ERR = 2'd2;
	localparam logic [1:0] ST_SEQ_ERR = 2'd3;

	// Bytes left at which the read switches to the two-byte tail
	localparam logic [7:0] READ_TAIL = 8'd3;

	typedef struct packed {
		req_kind_t  kind;
		mode_t      new_mode;
		logic [7:0] addr;
		logic [7:0] reg_num;
		logic [7:0] len;
		sig_t       sig;
		logic       er_ack_fail;
		logic       er_wr_stop;
		logic [7:0] data_a;
		logic [7:0] data_b;
	} req_t;

	typedef struct packed {
		logic       gen_start;
		logic       gen_stop;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [1:0] ack_ctrl;
		logic [1:0] reset_ctrl;
		logic [1:0] rx_count;
		logic [7:0] rx_first;
		logic [7:0] rx_second;
		logic [1:0] status;
	} res_t;

	function automatic act_t act_lookup(mode_t m, phase_t p, sig_t s);
		act_t a;
		a = A_SEQ;
		if (s == SIG_ERR) begin
			a = A_BUS;
		end else begin
			case (p)
				P_START: begin
					if (s == SIG_SB) a = A_ADDR_W;
				end
				P_ADDR: begin
					if (s == SIG_ADDR) a = (m == MODE_WR) ? A_REG : A_REG_RS;
				end
				P_REG: begin
					if (m == MODE_WR) begin
						if (s inside {SIG_ADDR, SIG_TXE}) a = A_NOP;
						else if (s == SIG_BTF) a = A_DATA;
					end else begin
						if (s == SIG_SB) a = A_ADDR_R;
						else if (s inside {SIG_BTF, SIG_TXE}) a = A_NOP;
					end
				end
				P_XFER: begin
					case (m)
						MODE_RD1: begin
							if (s == SIG_ADDR) a = A_LEN1;
							else if (s == SIG_RXNE) a = A_FIN;
							else if (s == SIG_TXE) a = A_NOP;
						end
						MODE_RDN: begin
							if (s == SIG_BTF) a = A_RDBTF;
							else if (s != SIG_SB) a = A_NOP;
						end
						MODE_WR: begin
							if (s == SIG_BTF) a = A_FIN;
							else if (s == SIG_TXE) a = A_NOP;
						end
						default: a = A_SEQ;
					endcase
				end
				P_TAIL: begin
					if (m == MODE_RDN && s == SIG_RXNE) a = A_FIN;
				end
				default: a = A_SEQ;
			endcase
		end
		return a;
	endfunction

endpackage

// ----- hdl/i2crf_ifs.sv -----
interface i2crf_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] slave_addr;
	logic [7:0] start_reg;
	logic [7:0] length;
	logic [4:0] event_flags;
	logic [6:0] error_flags;
	logic [7:0] data_a;
	logic [7:0] data_b;

	modport source (
		output valid, opcode, slave_addr, start_reg, length,
		output event_flags, error_flags, data_a, data_b,
		input  ready
	);
	modport sink (
		input  valid, opcode, slave_addr, start_reg, length,
		input  event_flags, error_flags, data_a, data_b,
		output ready
	);
endinterface

interface i2crf_rsp_if;
	logic       valid;
	logic       ready;
	logic       gen_start;
	logic       gen_stop;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic [1:0] ack_ctrl;
	logic [1:0] reset_ctrl;
	logic [1:0] rx_count;
	logic [7:0] rx_first;
	logic [7:0] rx_second;
	logic [1:0] status;

	modport source (
		output valid, gen_start, gen_stop, tx_valid, tx_byte, ack_ctrl,
		output reset_ctrl, rx_count, rx_first, rx_second, status,
		input  ready
	);
	modport sink (
		input  valid, gen_start, gen_stop, tx_valid, tx_byte, ack_ctrl,
		input  reset_ctrl, rx_count, rx_first, rx_second, status,
		output ready
	);
endinterface

// ----- hdl/i2crf_front.sv -----
module i2crf_front
	import i2crf_pkg::*;
(
	i2crf_cmd_if.sink cmd,
	input  logic      full,
	output logic      push,
	output req_t      req
);

	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;

	// Reduce the request to one kind and one prioritized event
	always_comb begin
		req             = '0;
		req.kind        = REQ_NOP;
		req.new_mode    = MODE_NONE;
		req.sig         = SIG_ERR;
		req.addr        = cmd.slave_addr;
		req.reg_num     = cmd.start_reg;
		req.len         = cmd.length;
		req.data_a      = cmd.data_a;
		req.data_b      = cmd.data_b;
		req.er_ack_fail = cmd.error_flags[1];
		req.er_wr_stop  = cmd.error_flags[0] | cmd.error_flags[1] | cmd.error_flags[3];
		case (cmd.opcode)
			OP_READ: begin
				req.kind     = REQ_START;
				req.new_mode = (cmd.length == 8'd1) ? MODE_RD1 : MODE_RDN;
			end
			OP_WRITE: begin
				req.kind     = REQ_START;
				req.new_mode = MODE_WR;
			end
			OP_EVENT: begin
				req.kind = REQ_EVENT;
				if (cmd.event_flags[0])      req.sig = SIG_SB;
				else if (cmd.event_flags[1]) req.sig = SIG_ADDR;
				else if (cmd.event_flags[2]) req.sig = SIG_BTF;
				else if (cmd.event_flags[3]) req.sig = SIG_RXNE;
				else if (cmd.event_flags[4]) req.sig = SIG_TXE;
				else if (|cmd.error_flags)   req.sig = SIG_ERR;
				else                         req.kind = REQ_NOP;
			end
			default: req.kind = REQ_NOP;
		endcase
	end

endmodule

// ----- hdl/i2crf_queue.sv -----
module i2crf_queue
	import i2crf_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t wr_data,
	input  logic pop,
	output req_t rd_data,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	req_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");

endmodule

// ----- hdl/i2crf_back.sv -----
module i2crf_back
	import i2crf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  req_t       req,
	output logic       pop,
	i2crf_rsp_if.source rsp
);

	phase_t     phase_q, phase_nxt;
	mode_t      mode_q, mode_nxt;
	logic [7:0] remaining_q, remaining_nxt;
	logic [7:0] addr_q, addr_nxt;
	logic [7:0] reg_q, reg_nxt;
	logic       out_valid_q;
	res_t       res_q, res_nxt;
	act_t       act;
	logic       is_write;

	assign pop      = !empty && (!out_valid_q || rsp.ready);
	assign is_write = (mode_q == MODE_WR);
	assign act      = act_lookup(mode_q, phase_q, req.sig);

	always_comb begin
		res_nxt       = '0;
		phase_nxt     = phase_q;
		mode_nxt      = mode_q;
		remaining_nxt = remaining_q;
		addr_nxt      = addr_q;
		reg_nxt       = reg_q;
		if (req.kind == REQ_START) begin
			addr_nxt          = req.addr;
			reg_nxt           = req.reg_num;
			remaining_nxt     = req.len;
			mode_nxt          = req.new_mode;
			phase_nxt         = P_START;
			res_nxt.gen_start = 1'b1;
		end else if (req.kind == REQ_EVENT && mode_q != MODE_NONE) begin
			case (act)
				A_SEQ: begin
					if (is_write) begin
						res_nxt.reset_ctrl = RST_CYCLE;
						res_nxt.status     = ST_BUS_ERR;
					end else begin
						res_nxt.ack_ctrl   = ACK_ENABLE;
						res_nxt.gen_stop   = 1'b1;
						res_nxt.reset_ctrl = RST_SWRST;
						res_nxt.status     = ST_SEQ_ERR;
					end
					phase_nxt = P_IDLE;
				end
				A_BUS: begin
					if (is_write) begin
						res_nxt.gen_stop = req.er_wr_stop;
					end else begin
						res_nxt.gen_stop = req.er_ack_fail;
						res_nxt.ack_ctrl = ACK_ENABLE;
					end
					res_nxt.status = ST_BUS_ERR;
					phase_nxt      = P_IDLE;
				end
				A_ADDR_W: begin
					res_nxt.tx_valid = 1'b1;
					res_nxt.tx_byte  = {addr_q[7:1], 1'b0};
					phase_nxt        = P_ADDR;
				end
				A_REG, A_REG_RS: begin
					res_nxt.tx_valid  = 1'b1;
					res_nxt.tx_byte   = reg_q;
					res_nxt.gen_start = (act == A_REG_RS);
					phase_nxt         = P_REG;
				end
				A_ADDR_R: begin
					res_nxt.tx_valid = 1'b1;
					res_nxt.tx_byte  = {addr_q[7:1], 1'b1};
					phase_nxt        = P_XFER;
				end
				A_RDBTF: begin
					res_nxt.rx_first = req.data_a;
					if (remaining_q > READ_TAIL) begin
						res_nxt.rx_count = 2'd1;
						remaining_nxt    = remaining_q - 8'd1;
					end else begin
						res_nxt.ack_ctrl  = ACK_DISABLE;
						res_nxt.gen_stop  = 1'b1;
						res_nxt.rx_count  = 2'd2;
						res_nxt.rx_second = req.data_b;
						remaining_nxt     = remaining_q - 8'd2;
						phase_nxt         = P_TAIL;
					end
				end
				A_FIN: begin
					if (!is_write) begin
						if (remaining_q == 8'd1) begin
							res_nxt.rx_count = 2'd1;
							res_nxt.rx_first = req.data_a;
						end
						res_nxt.ack_ctrl = ACK_ENABLE;
					end
					res_nxt.status = ST_DONE;
					phase_nxt      = P_IDLE;
				end
				A_LEN1: begin
					res_nxt.ack_ctrl = ACK_DISABLE;
					res_nxt.gen_stop = 1'b1;
				end
				A_DATA: begin
					res_nxt.tx_valid = 1'b1;
					res_nxt.tx_byte  = req.data_a;
					if (remaining_q != 8'd1) begin
						remaining_nxt = remaining_q - 8'd1;
						phase_nxt     = P_REG;
					end else begin
						remaining_nxt    = 8'd0;
						res_nxt.gen_stop = 1'b1;
						phase_nxt        = P_XFER;
					end
				end
				default: res_nxt = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_IDLE;
			mode_q      <= MODE_NONE;
			remaining_q <= '0;
			addr_q      <= '0;
			reg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_nxt;
				mode_q      <= mode_nxt;
				remaining_q <= remaining_nxt;
				addr_q      <= addr_nxt;
				reg_q       <= reg_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) res_q <= res_nxt;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.gen_start  = res_q.gen_start;
	assign rsp.gen_stop   = res_q.gen_stop;
	assign rsp.tx_valid   = res_q.tx_valid;
	assign rsp.tx_byte    = res_q.tx_byte;
	assign rsp.ack_ctrl   = res_q.ack_ctrl;
	assign rsp.reset_ctrl = res_q.reset_ctrl;
	assign rsp.rx_count   = res_q.rx_count;
	assign rsp.rx_first   = res_q.rx_first;
	assign rsp.rx_second  = res_q.rx_second;
	assign rsp.status     = res_q.status;

	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q)) else $error("phase register not one-hot");
	a_idle_unarmed: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_NONE |-> phase_q == P_IDLE)
		else $error("phase advanced with no transfer armed");
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop && res_nxt.status != ST_BUSY |=> phase_q == P_IDLE)
		else $error("transfer ended but phase did not return to idle");
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.tx_valid |-> res_q.tx_byte == 8'd0)
		else $error("tx byte set without tx_valid");

endmodule

// ----- hdl/i2c_master_register_transaction_fsm_top.sv -----
// I2C master register read/write sequencer. Send a start request (opcode 1 read,
// 2 write) with slave address, first register and length; it answers with a START
// request and arms the transfer. Then forward every controller status snapshot as
// an event request (opcode 0): event flags are taken by priority start, address,
// byte finished, rx not empty, tx empty, then any error flag, and each step emits
// the bytes to transmit, START/STOP and ACK control, received bytes and a final
// status. Every accepted request yields exactly one response, in order; requests
// with no flags or opcode 3 give an all-zero response. Rate: one request per clock
// sustained while responses are taken, set by the combinational state-table step in
// the sequencer; each request is registered in the queue and then in the response
// register. The queue (QUEUE_DEPTH entries) lets request intake continue while a
// response waits to be taken.
module i2c_master_register_transaction_fsm_top
	import i2crf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	i2crf_cmd_if.sink   cmd,
	i2crf_rsp_if.source rsp
);

	logic push;
	logic pop;
	logic full;
	logic empty;
	req_t req_in;
	req_t req_out;

	// Classify incoming requests
	i2crf_front u_front (
		.cmd  (cmd),
		.full (full),
		.push (push),
		.req  (req_in)
	);

	// Hold classified requests between intake and sequencer
	i2crf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (req_in),
		.pop     (pop),
		.rd_data (req_out),
		.full    (full),
		.empty   (empty)
	);

	// Advance the transfer state and drive the response register
	i2crf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.req    (req_out),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

// ----- test/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import i2crf_pkg::*;

	// Opcode with no meaning to the block; the request must come back all zero.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Sequencer phases as tracked by the predictor (binary, unlike the RTL).
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_ADDR  = 3'd2;
	localparam logic [2:0] PH_REG   = 3'd3;
	localparam logic [2:0] PH_XFER  = 3'd4;
	localparam logic [2:0] PH_TAIL  = 3'd5;

	localparam int RANDOM_ITEMS = 1400;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] slave_addr;
		logic [7:0] start_reg;
		logic [7:0] length;
		logic [4:0] event_flags;
		logic [6:0] error_flags;
		logic [7:0] data_a;
		logic [7:0] data_b;
	} cmd_t;

	typedef struct {
		cmd_t cmd;
		bit   typed;
		res_t want;
	} script_row_t;

	logic clk;
	logic arst_n;

	i2crf_cmd_if cmd_bus ();
	i2crf_rsp_if rsp_bus ();

	i2c_master_register_transaction_fsm_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// Predicted transfer state, mirrors the sequencer after every accepted request.
	logic [2:0] cur_phase  = PH_IDLE;
	mode_t      cur_mode   = MODE_NONE;
	logic [7:0] bytes_left = 8'd0;
	logic [7:0] cur_addr   = 8'd0;
	logic [7:0] cur_reg    = 8'd0;

	// Action per [mode - 1][phase][signal]; signals SB, ADDR, BTF, RXNE, TXE, error.
	act_t act_map [3][6][6] = '{
		'{ // read of one byte
			'{A_SEQ,    A_SEQ,    A_SEQ,  A_SEQ, A_SEQ, A_BUS},
			'{A_ADDR_W, A_SEQ,    A_SEQ,  A_SEQ, A_SEQ, A_BUS},
			'{A_SEQ,    A_REG_RS, A_SEQ,  A_SEQ, A_SEQ, A_BUS},
			'{A_ADDR_R, A_SEQ,    A_NOP,  A_SEQ, A_NOP, A_BUS},
			'{A_SEQ,    A_LEN1,   A_SEQ,  A_FIN, A_NOP, A_BUS},
			'{A_SEQ,    A_SEQ,    A_SEQ,  A_SEQ, A_SEQ, A_BUS}
		},
		'{ // read of any length but one
			'{A_SEQ,    A_SEQ,    A_SEQ,    A_SEQ, A_SEQ, A_BUS},
			'{A_ADDR_W, A_SEQ,    A_SEQ,    A_SEQ, A_SEQ, A_BUS},
			'{A_SEQ,    A_REG_RS, A_SEQ,    A_SEQ, A_SEQ, A_BUS},
			'{A_ADDR_R, A_SEQ,    A_NOP,    A_SEQ, A_NOP, A_BUS},
			'{A_SEQ,    A_NOP,    A_RDBTF,  A_NOP, A_NOP, A_BUS},
			'{A_SEQ,    A_SEQ,    A_SEQ,    A_FIN, A_SEQ, A_BUS}
		},
		'{ // write
			'{A_SEQ,    A_SEQ,    A_SEQ,  A_SEQ, A_SEQ, A_BUS},
			'{A_ADDR_W, A_SEQ,    A_SEQ,  A_SEQ, A_SEQ, A_BUS},
			'{A_SEQ,    A_REG,    A_SEQ,  A_SEQ, A_SEQ, A_BUS},
			'{A_SEQ,    A_NOP,    A_DATA, A_SEQ, A_NOP, A_BUS},
			'{A_SEQ,    A_SEQ,    A_FIN,  A_SEQ, A_NOP, A_BUS},
			'{A_SEQ,    A_SEQ,    A_SEQ,  A_SEQ, A_SEQ, A_BUS}
		}
	};

	res_t        pending_results [$];
	script_row_t directed_rows [$];
	int          error_count   = 0;
	int          cycle_count   = 0;
	int          requests_done = 0;
	bit          no_idle       = 1'b0;
	bit          hold_rsp      = 1'b0;
	bit          clean_run     = 1'b0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Guard against a hung handshake: drop out with a failure well past the slowest run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic cmd_t mk_cmd(logic [1:0] op, logic [7:0] addr, logic [7:0] reg_num,
			logic [7:0] len, logic [4:0] ev, logic [6:0] er, logic [7:0] da, logic [7:0] db);
		cmd_t c;
		c = '{op, addr, reg_num, len, ev, er, da, db};
		return c;
	endfunction

	function automatic res_t mk_res(logic start, logic stop, logic txv, logic [7:0] txb,
			logic [1:0] ack, logic [1:0] rst, logic [1:0] cnt, logic [7:0] first,
			logic [7:0] second, logic [1:0] st);
		res_t r;
		r = '{start, stop, txv, txb, ack, rst, cnt, first, second, st};
		return r;
	endfunction

	task automatic add_row(input cmd_t c, input bit typed, input res_t want);
		script_row_t row;
		row.cmd   = c;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	// Advance the predicted sequencer by one request and return the response it owes.
	function automatic res_t step_sequencer(cmd_t c);
		res_t       r;
		sig_t       s;
		act_t       a;
		logic [2:0] row;
		bit         is_wr;
		r     = '0;
		is_wr = (cur_mode == MODE_WR);
		if (c.opcode == OP_READ || c.opcode == OP_WRITE) begin
			cur_addr   = c.slave_addr;
			cur_reg    = c.start_reg;
			bytes_left = c.length;
			if (c.opcode == OP_WRITE)
				cur_mode = MODE_WR;
			else
				cur_mode = (c.length == 8'd1) ? MODE_RD1 : MODE_RDN;
			cur_phase   = PH_START;
			r.gen_start = 1'b1;
			return r;
		end
		if (c.opcode != OP_EVENT || cur_mode == MODE_NONE)
			return r;

		// Reduce the flags to one signal by priority; no flag at all means no action.
		if (c.event_flags[0])           s = SIG_SB;
		else if (c.event_flags[1])      s = SIG_ADDR;
		else if (c.event_flags[2])      s = SIG_BTF;
		else if (c.event_flags[3])      s = SIG_RXNE;
		else if (c.event_flags[4])      s = SIG_TXE;
		else if (c.error_flags != 7'd0) s = SIG_ERR;
		else return r;

		row = (cur_phase <= PH_TAIL) ? cur_phase : PH_IDLE;
		a   = act_map[int'(cur_mode) - 1][row][s];

		case (a)
			A_SEQ: begin
				if (is_wr) begin
					r.reset_ctrl = RST_CYCLE;
					r.status     = ST_BUS_ERR;
				end else begin
					r.ack_ctrl   = ACK_ENABLE;
					r.gen_stop   = 1'b1;
					r.reset_ctrl = RST_SWRST;
					r.status     = ST_SEQ_ERR;
				end
				cur_phase = PH_IDLE;
			end
			A_BUS: begin
				if (is_wr) begin
					// STOP on bus error, ack fail or overrun only
					r.gen_stop = c.error_flags[0] | c.error_flags[1] | c.error_flags[3];
				end else begin
					r.gen_stop = c.error_flags[1];
					r.ack_ctrl = ACK_ENABLE;
				end
				r.status  = ST_BUS_ERR;
				cur_phase = PH_IDLE;
			end
			A_ADDR_W: begin
				r.tx_valid = 1'b1;
				r.tx_byte  = cur_addr & 8'hfe;
				cur_phase  = PH_ADDR;
			end
			A_REG: begin
				r.tx_valid = 1'b1;
				r.tx_byte  = cur_reg;
				cur_phase  = PH_REG;
			end
			A_REG_RS: begin
				r.tx_valid  = 1'b1;
				r.tx_byte   = cur_reg;
				r.gen_start = 1'b1;
				cur_phase   = PH_REG;
			end
			A_ADDR_R: begin
				r.tx_valid = 1'b1;
				r.tx_byte  = cur_addr | 8'h01;
				cur_phase  = PH_XFER;
			end
			A_RDBTF: begin
				if (bytes_left > READ_TAIL) begin
					r.rx_count = 2'd1;
					r.rx_first = c.data_a;
					bytes_left = bytes_left - 8'd1;
				end else begin
					// Two bytes left in the shifter: NACK the last and schedule STOP
					r.ack_ctrl  = ACK_DISABLE;
					r.gen_stop  = 1'b1;
					r.rx_count  = 2'd2;
					r.rx_first  = c.data_a;
					r.rx_second = c.data_b;
					bytes_left  = bytes_left - 8'd2;
					cur_phase   = PH_TAIL;
				end
			end
			A_FIN: begin
				if (!is_wr) begin
					if (bytes_left == 8'd1) begin
						r.rx_count = 2'd1;
						r.rx_first = c.data_a;
					end
					r.ack_ctrl = ACK_ENABLE;
				end
				r.status  = ST_DONE;
				cur_phase = PH_IDLE;
			end
			A_LEN1: begin
				r.ack_ctrl = ACK_DISABLE;
				r.gen_stop = 1'b1;
			end
			A_DATA: begin
				r.tx_valid = 1'b1;
				r.tx_byte  = c.data_a;
				if (bytes_left != 8'd1) begin
					bytes_left = bytes_left - 8'd1;
					cur_phase  = PH_REG;
				end else begin
					bytes_left = 8'd0;
					r.gen_stop = 1'b1;
					cur_phase  = PH_XFER;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Build the next random request, mostly the one the transfer in flight is waiting for.
	function automatic cmd_t next_request();
		cmd_t c;
		sig_t want;
		int   roll;
		c.opcode      = OP_EVENT;
		c.slave_addr  = 8'($urandom);
		c.start_reg   = 8'($urandom);
		c.length      = 8'($urandom);
		c.event_flags = 5'($urandom);
		c.error_flags = 7'($urandom);
		c.data_a      = 8'($urandom);
		c.data_b      = 8'($urandom);

		// Noise: anything at all, including bare errors, empty events and restarts.
		if ($urandom_range(0, 99) < (clean_run ? 1 : 15)) begin
			c.opcode = 2'($urandom_range(0, 3));
			roll     = $urandom_range(0, 3);
			if (roll == 0) begin
				c.event_flags = 5'd0;
			end else if (roll == 1) begin
				c.event_flags = 5'd0;
				c.error_flags = 7'd0;
			end
			return c;
		end

		if (cur_mode == MODE_NONE || cur_phase == PH_IDLE) begin
			c.opcode  = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
			clean_run = ($urandom_range(0, 4) != 0);
			roll      = $urandom_range(0, 99);
			// Keep most transfers short; the long ones cost hundreds of requests.
			if (roll == 0)      c.length = 8'd0;
			else if (roll == 1) c.length = 8'd255;
			else if (roll < 4)  c.length = 8'($urandom_range(1, 255));
			else                c.length = 8'($urandom_range(1, 6));
			return c;
		end

		case (cur_phase)
			PH_START: want = SIG_SB;
			PH_ADDR:  want = SIG_ADDR;
			PH_REG:   want = (cur_mode == MODE_WR) ? SIG_BTF : SIG_SB;
			PH_XFER: begin
				if (cur_mode == MODE_RD1)
					want = $urandom_range(0, 1) ? SIG_ADDR : SIG_RXNE;
				else
					want = SIG_BTF;
			end
			default:  want = SIG_RXNE;
		endcase
		if ($urandom_range(0, 9) == 0)
			want = SIG_TXE;
		// Set the wanted flag and clear every flag of higher priority.
		c.event_flags = (c.event_flags & ~((5'd1 << want) - 5'd1)) | (5'd1 << want);
		return c;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Present one request and return at the rising edge that accepts it.
	task automatic offer_request(input cmd_t c);
		cmd_bus.valid       <= 1'b1;
		cmd_bus.opcode      <= c.opcode;
		cmd_bus.slave_addr  <= c.slave_addr;
		cmd_bus.start_reg   <= c.start_reg;
		cmd_bus.length      <= c.length;
		cmd_bus.event_flags <= c.event_flags;
		cmd_bus.error_flags <= c.error_flags;
		cmd_bus.data_a      <= c.data_a;
		cmd_bus.data_b      <= c.data_b;
		do
			@(negedge clk);
		while (cmd_bus.ready !== 1'b1);
		@(posedge clk);
	endtask

	// Drop valid for a random gap, or until every response is in when draining.
	task automatic rest_sender(input bit drain);
		int gap;
		gap = pick_gap();
		if (drain || gap > 0) begin
			cmd_bus.valid <= 1'b0;
			while (drain && pending_results.size() != 0)
				@(posedge clk);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	// Response side: compare every accepted response against the oldest expectation.
	// Sample at the falling edge, where valid, ready and payload are settled.
	always @(negedge clk) begin
		res_t want;
		if (arst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("response with no request pending");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("gen_start",  want.gen_start,  rsp_bus.gen_start);
				check_field("gen_stop",   want.gen_stop,   rsp_bus.gen_stop);
				check_field("tx_valid",   want.tx_valid,   rsp_bus.tx_valid);
				check_field("tx_byte",    want.tx_byte,    rsp_bus.tx_byte);
				check_field("ack_ctrl",   want.ack_ctrl,   rsp_bus.ack_ctrl);
				check_field("reset_ctrl", want.reset_ctrl, rsp_bus.reset_ctrl);
				check_field("rx_count",   want.rx_count,   rsp_bus.rx_count);
				check_field("rx_first",   want.rx_first,   rsp_bus.rx_first);
				check_field("rx_second",  want.rx_second,  rsp_bus.rx_second);
				check_field("status",     want.status,     rsp_bus.status);
			end
		end
	end

	// Response ready: random stalls, calm stretches, and one long hold-off on request
	// so the block's queue fills and it pushes back on the request side.
	initial begin
		int stall;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (no_idle) begin
				rsp_bus.ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 3) begin
				stall = $urandom_range(8, 40);
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end else begin
				rsp_bus.ready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	initial begin
		script_row_t row;
		cmd_t        c;
		res_t        predicted;
		bit          counts;
		bit          hold_done;
		bit          drain_done;
		hold_done  = 1'b0;
		drain_done = 1'b0;

		// Hold every input at a known value and keep reset asserted.
		arst_n              <= 1'b0;
		cmd_bus.valid       <= 1'b0;
		cmd_bus.opcode      <= OP_EVENT;
		cmd_bus.slave_addr  <= 8'd0;
		cmd_bus.start_reg   <= 8'd0;
		cmd_bus.length      <= 8'd0;
		cmd_bus.event_flags <= 5'd0;
		cmd_bus.error_flags <= 7'd0;
		cmd_bus.data_a      <= 8'd0;
		cmd_bus.data_b      <= 8'd0;

		// Directed script. Typed rows carry the response that is plain from the
		// sequencer's behavior; the rest are left to the predictor.
		// Nothing armed after reset: every flag set is still ignored.
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h01, 5'h1f, 7'h7f, 8'hff, 8'hff), 1'b1,
			mk_res(0, 0, 0, 8'h00, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		add_row(mk_cmd(OP_UNUSED, 8'hff, 8'hff, 8'hff, 5'h1f, 7'h7f, 8'hff, 8'hff), 1'b1,
			mk_res(0, 0, 0, 8'h00, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		// One-byte read from the top address and register zero, run to completion.
		add_row(mk_cmd(OP_READ, 8'hff, 8'h00, 8'd1, 5'h00, 7'h00, 8'h00, 8'h00), 1'b1,
			mk_res(1, 0, 0, 8'h00, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h01, 7'h00, 8'h00, 8'h00), 1'b1,
			mk_res(0, 0, 1, 8'hfe, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h1e, 7'h00, 8'h00, 8'h00), 1'b1,
			mk_res(1, 0, 1, 8'h00, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h01, 7'h00, 8'h00, 8'h00), 1'b1,
			mk_res(0, 0, 1, 8'hff, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h02, 7'h00, 8'h00, 8'h00), 1'b1,
			mk_res(0, 1, 0, 8'h00, ACK_DISABLE, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h08, 7'h00, 8'ha5, 8'h5a), 1'b1,
			mk_res(0, 0, 0, 8'h00, ACK_ENABLE, RST_NONE, 2'd1, 8'ha5, 8'h00, ST_DONE));
		// Events after completion: sequence error, then a bus error on ack fail.
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h10, 7'h00, 8'h00, 8'h00), 1'b1,
			mk_res(0, 1, 0, 8'h00, ACK_ENABLE, RST_SWRST, 2'd0, 8'h00, 8'h00, ST_SEQ_ERR));
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h00, 7'h02, 8'h00, 8'h00), 1'b1,
			mk_res(0, 1, 0, 8'h00, ACK_ENABLE, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUS_ERR));
		add_row(mk_cmd(OP_EVENT, 8'hff, 8'hff, 8'hff, 5'h00, 7'h00, 8'hff, 8'hff), 1'b1,
			mk_res(0, 0, 0, 8'h00, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		// Write with length zero (wraps), one data byte, then errors.
		add_row(mk_cmd(OP_WRITE, 8'h00, 8'hff, 8'd0, 5'h00, 7'h00, 8'h00, 8'h00), 1'b1,
			mk_res(1, 0, 0, 8'h00, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h01, 7'h00, 8'h00, 8'h00), 1'b1,
			mk_res(0, 0, 1, 8'h00, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h02, 7'h00, 8'h00, 8'h00), 1'b1,
			mk_res(0, 0, 1, 8'hff, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUSY));
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h04, 7'h00, 8'h00, 8'hff), 1'b0, '0);
		// Alert alone: write bus error without STOP.
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h00, 7'h40, 8'h00, 8'h00), 1'b1,
			mk_res(0, 0, 0, 8'h00, ACK_KEEP, RST_NONE, 2'd0, 8'h00, 8'h00, ST_BUS_ERR));
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h01, 7'h00, 8'h00, 8'h00), 1'b1,
			mk_res(0, 0, 0, 8'h00, ACK_KEEP, RST_CYCLE, 2'd0, 8'h00, 8'h00, ST_BUS_ERR));
		// Restart a read while busy, with length zero, and run it through the tail.
		add_row(mk_cmd(OP_READ, 8'h5a, 8'h3c, 8'd5, 5'h00, 7'h00, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_cmd(OP_READ, 8'ha3, 8'hc3, 8'd0, 5'h00, 7'h00, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h1f, 7'h7f, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h02, 7'h00, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h01, 7'h00, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h04, 7'h00, 8'h11, 8'h22), 1'b0, '0);
		add_row(mk_cmd(OP_EVENT, 8'h00, 8'h00, 8'h00, 5'h08, 7'h00, 8'h33, 8'h44), 1'b0, '0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the script; the predictor runs on every row to keep its state in step.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			offer_request(row.cmd);
			predicted = step_sequencer(row.cmd);
			pending_results.push_back(row.typed ? row.want : predicted);
			rest_sender(1'b0);
		end

		// Random part: count only requests the block acts on.
		while (requests_done < RANDOM_ITEMS) begin
			c      = next_request();
			counts = (c.opcode == OP_READ || c.opcode == OP_WRITE) ||
				(c.opcode == OP_EVENT && cur_mode != MODE_NONE &&
				(c.event_flags != 5'd0 || c.error_flags != 7'd0));
			offer_request(c);
			pending_results.push_back(step_sequencer(c));
			if (counts)
				requests_done++;
			// Alternate idle-free stretches with randomly idling ones.
			no_idle = (requests_done % 450) >= 360;
			// Hold off the response side once while requests keep coming.
			if (requests_done >= 500 && !hold_done) begin
				hold_rsp  = 1'b1;
				hold_done = 1'b1;
			end
			if (requests_done >= 900 && !drain_done) begin
				drain_done = 1'b1;
				rest_sender(1'b1);
			end else begin
				rest_sender(1'b0);
			end
		end

		// Drain: drop valid, wait for the last responses, then give stragglers time.
		cmd_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
